// ===== sv/cti_pkg.sv =====
// shared types, constants and helpers for the calendar table interpolator
package cti_pkg;

	localparam int DOY_W     = 9;
	localparam int MIN_W     = 12;
	localparam int ENTRY_W   = DOY_W + MIN_W;
	localparam int IDX_W     = 5;
	localparam int DIV_W     = 21;
	localparam int DIVR_W    = 9;
	localparam int HOUR_W    = 6;
	localparam int MREM_W    = 6;
	localparam int RES_W     = 12;
	localparam int MINS_PER_HOUR = 60;
	localparam int HHMM_SCALE    = 100;
	localparam int RES_MAX       = 4095;
	// from this many hours on the result is past the 12-bit range
	localparam int HOUR_SAT      = 41;
	localparam int CNT_RESET     = 28;
	localparam int CFG_W         = 6;

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [IDX_W-1:0]   idx;
		logic [DOY_W-1:0]   doy;
		logic [MIN_W-1:0]   minutes;
		logic               bad;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic div_busy;
	} bk_stat_t;

	// first day offset of each month, non-leap year
	function automatic logic [DOY_W-1:0] month_start(input logic [3:0] m);
		logic [DOY_W-1:0] r;
		begin
			case (m)
				4'd1:    r = 9'd0;
				4'd2:    r = 9'd31;
				4'd3:    r = 9'd59;
				4'd4:    r = 9'd90;
				4'd5:    r = 9'd120;
				4'd6:    r = 9'd151;
				4'd7:    r = 9'd181;
				4'd8:    r = 9'd212;
				4'd9:    r = 9'd243;
				4'd10:   r = 9'd273;
				4'd11:   r = 9'd304;
				4'd12:   r = 9'd334;
				default: r = 9'd0;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== sv/cti_ram.sv =====
// generic single write port ram with registered read
module cti_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/cti_queue.sv =====
// two entry command queue between front and back
module cti_queue
	import cti_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== sv/cti_div.sv =====
// restoring divider, one quotient bit per cycle
module cti_div
	import cti_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [DIVR_W-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [DIV_W-1:0]  quo,
	output logic [DIVR_W-1:0] rem
);

	localparam int CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0]  dq_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVR_W:0]   trial;
	logic              ge;

	assign trial = {rem_q, dq_q[DIV_W-1]};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIV_W-2:0], ge};
			rem_q <= ge ? DIVR_W'(trial - {1'b0, dvs_q}) : DIVR_W'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = dq_q;
	assign rem  = rem_q;

endmodule

// ===== sv/cti_front.sv =====
// front: takes items, converts date and time, hands commands to the queue
module cti_front
	import cti_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             func,
	input  logic [IDX_W-1:0] entry_index,
	input  logic [3:0]       month,
	input  logic [4:0]       day,
	input  logic [11:0]      time_hhmm,
	output logic             push_valid,
	input  logic             push_ready,
	output cmd_t             push_data
);

	logic             v_s1;
	logic             func_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [3:0]       month_s1;
	logic [4:0]       day_s1;
	logic [11:0]      t_s1;
	logic             bad;
	logic [11:0]      r;
	logic [5:0]       h;

	assign in_ready   = !v_s1 || push_ready;
	assign push_valid = v_s1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1  <= func;
			idx_s1   <= entry_index;
			month_s1 <= month;
			day_s1   <= day;
			t_s1     <= time_hhmm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_comb begin
		bad = (month_s1 < 4'd1) || (month_s1 > 4'd12) || (day_s1 == 5'd0);
		// split hhmm into hours and minutes, one hour bit per step
		r = t_s1;
		h = '0;
		for (int k = 5; k >= 0; k--) begin
			if (r >= 12'(HHMM_SCALE << k)) begin
				r    = r - 12'(HHMM_SCALE << k);
				h[k] = 1'b1;
			end
		end
		push_data.func    = func_t'(func_s1);
		push_data.idx     = idx_s1;
		push_data.bad     = bad;
		push_data.doy     = bad ? '0 : month_start(month_s1) + DOY_W'(day_s1);
		push_data.minutes = 12'(h) * 12'(MINS_PER_HOUR) + r;
	end

endmodule

// ===== sv/cti_back.sv =====
// back: table writes, breakpoint walk and interpolation
module cti_back
	import cti_pkg::*;
#(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  cmd_t                          pop_data,
	input  logic [$clog2(TABLE_DEPTH):0]  count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [RES_W-1:0]              result_hhmm,
	output logic                          bad_date,
	output bk_stat_t                      stat
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = AW + 1;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_WALK = 8'b0000_0010,
		ST_MUL  = 8'b0000_0100,
		ST_SUM  = 8'b0000_1000,
		ST_DIV1 = 8'b0001_0000,
		ST_HRS  = 8'b0010_0000,
		ST_CALC = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} state_t;

	state_t                   state_q;
	logic [AW-1:0]            cur_q;
	logic [DOY_W-1:0]         tgt_q;
	logic                     bad_q;
	logic [DOY_W-1:0]         prev_doy_q;
	logic [MIN_W-1:0]         prev_min_q;
	logic [DOY_W-1:0]         s_doy_q;
	logic [MIN_W-1:0]         s_min_q;
	logic [DOY_W-1:0]         e_doy_q;
	logic [MIN_W-1:0]         e_min_q;
	logic signed [22:0]       p1_q;
	logic signed [22:0]       p2_q;
	logic signed [DOY_W:0]    size_q;
	logic [DIVR_W-1:0]        den_q;
	logic                     rnd_q;
	logic [HOUR_W-1:0]        h_q;
	logic [MREM_W-1:0]        m_q;
	logic                     sat_q;
	logic [RES_W-1:0]         res_q;
	logic                     out_valid_q;
	logic [RES_W-1:0]         out_res_q;
	logic                     out_bad_q;

	logic                     we;
	logic [AW-1:0]            waddr;
	logic [AW-1:0]            raddr;
	logic [ENTRY_W-1:0]       rdata;
	logic [DOY_W-1:0]         rd_doy;
	logic [MIN_W-1:0]         rd_min;
	logic                     adv;
	logic [5:0]               pr;
	logic signed [DOY_W:0]    size_c;
	logic signed [DOY_W:0]    dt_c;
	logic signed [MIN_W:0]    dm_c;
	logic signed [MIN_W:0]    sm_c;
	logic signed [22:0]       sum_c;
	logic signed [22:0]       num_c;
	logic [DIVR_W-1:0]        den_c;
	logic                     div_start;
	logic [DIV_W-1:0]         div_dividend;
	logic [DIVR_W-1:0]        div_divisor;
	logic                     div_busy;
	logic                     div_done;
	logic [DIV_W-1:0]         div_quo;
	logic [DIVR_W-1:0]        div_rem;
	logic [21:0]              r_c;
	logic                     hr_sat;
	logic [MIN_W-1:0]         hr_r;
	logic [HOUR_W-1:0]        hr_h;

	// load index wraps onto the table depth
	always_comb begin
		pr = {1'b0, pop_data.idx};
		for (int k = 4; k >= 0; k--) begin
			if (32'(pr) >= (TABLE_DEPTH << k)) begin
				pr = pr - 6'(TABLE_DEPTH << k);
			end
		end
		waddr = AW'(pr);
	end

	assign pop_ready = (state_q == ST_IDLE);
	assign we        = (state_q == ST_IDLE) && pop_valid && (pop_data.func == FUNC_LOAD);
	assign raddr     = (state_q == ST_IDLE) ? '0 : cur_q + 1'b1;
	assign rd_doy    = rdata[ENTRY_W-1:MIN_W];
	assign rd_min    = rdata[MIN_W-1:0];
	assign adv       = (tgt_q > rd_doy) && ((CW'(cur_q) + 1'b1) < count);

	cti_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata ({pop_data.doy, pop_data.minutes}),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		size_c = $signed({1'b0, e_doy_q}) - $signed({1'b0, s_doy_q});
		dt_c   = $signed({1'b0, tgt_q}) - $signed({1'b0, s_doy_q});
		dm_c   = $signed({1'b0, e_min_q}) - $signed({1'b0, s_min_q});
		sm_c   = $signed({1'b0, s_min_q});
		sum_c  = p1_q + p2_q;
		if (size_q == '0) begin
			num_c = 23'(sm_c);
			den_c = DIVR_W'(1);
		end else if (size_q < 0) begin
			num_c = -sum_c;
			den_c = DIVR_W'(-size_q);
		end else begin
			num_c = sum_c;
			den_c = DIVR_W'(size_q);
		end
		div_start    = (state_q == ST_SUM) && !num_c[22];
		div_dividend = DIV_W'(num_c);
		div_divisor  = den_c;
		r_c = 22'(h_q) * 22'(HHMM_SCALE) + 22'(m_q) + 22'(rnd_q);
	end

	// whole minutes into hours and minutes, one hour bit per step
	always_comb begin
		hr_sat = (div_quo >= DIV_W'(HOUR_SAT * MINS_PER_HOUR));
		hr_r   = MIN_W'(div_quo);
		hr_h   = '0;
		for (int k = HOUR_W - 1; k >= 0; k--) begin
			if (hr_r >= MIN_W'(MINS_PER_HOUR << k)) begin
				hr_r    = hr_r - MIN_W'(MINS_PER_HOUR << k);
				hr_h[k] = 1'b1;
			end
		end
	end

	cti_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				tgt_q <= pop_data.doy;
				bad_q <= pop_data.bad;
				cur_q <= '0;
			end
			ST_WALK: begin
				if (adv) begin
					prev_doy_q <= rd_doy;
					prev_min_q <= rd_min;
					cur_q      <= cur_q + 1'b1;
				end else begin
					e_doy_q <= rd_doy;
					e_min_q <= rd_min;
					// first entry: segment collapses onto itself
					s_doy_q <= (cur_q == '0) ? rd_doy : prev_doy_q;
					s_min_q <= (cur_q == '0) ? rd_min : prev_min_q;
				end
			end
			ST_MUL: begin
				p1_q   <= sm_c * size_c;
				p2_q   <= dt_c * dm_c;
				size_q <= size_c;
			end
			ST_SUM: begin
				den_q <= den_c;
				res_q <= '0;
			end
			ST_DIV1: begin
				if (div_done) begin
					rnd_q <= ({div_rem, 1'b0} >= {1'b0, den_q});
				end
			end
			ST_HRS: begin
				h_q   <= hr_h;
				m_q   <= MREM_W'(hr_r);
				sat_q <= hr_sat;
			end
			ST_CALC: begin
				res_q <= (sat_q || (r_c > 22'(RES_MAX))) ? RES_W'(RES_MAX) : RES_W'(r_c);
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_res_q <= res_q;
					out_bad_q <= bad_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid && (pop_data.func == FUNC_QUERY)) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (!adv) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_SUM;
				ST_SUM: state_q <= num_c[22] ? ST_OUT : ST_DIV1;
				ST_DIV1: begin
					if (div_done) begin
						state_q <= ST_HRS;
					end
				end
				ST_HRS: state_q <= ST_CALC;
				ST_CALC: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign result_hhmm   = out_res_q;
	assign bad_date      = out_bad_q;
	assign stat.busy     = (state_q != ST_IDLE);
	assign stat.div_busy = div_busy;

endmodule

// ===== sv/calendar_table_interpolator_top.sv =====
// top level of the calendar table interpolator
//
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    func, entry_index, month, day, time_hhmm
// out       output     out_valid/out_ready  result_hhmm, bad_date
// cfg       input      cfg_valid/cfg_ready  cfg_data (entry_count)
//
// a load passes through the front register and the queue before the table write
// a query walks the table, reading one entry a cycle through the table's single read port,
// then, unless the interpolation numerator is negative, runs one bit-serial divide;
// hours and minutes come from a compare and subtract step
// a two-entry queue lets the front keep taking items while the back is busy
// reset clears control state only; entry_count returns to 28
module calendar_table_interpolator_top
	import cti_pkg::*;
#(
	parameter int TABLE_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [3:0]        month,
	input  logic [4:0]        day,
	input  logic [11:0]       time_hhmm,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [RES_W-1:0]  result_hhmm,
	output logic              bad_date,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int CW = $clog2(TABLE_DEPTH) + 1;

	logic [CFG_W-1:0] entry_count_q;
	logic [CW-1:0]    cnt;
	logic             push_valid;
	logic             push_ready;
	cmd_t             push_data;
	logic             pop_valid;
	logic             pop_ready;
	cmd_t             pop_data;
	bk_stat_t         stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= CFG_W'(CNT_RESET);
		end else if (cfg_valid && cfg_ready) begin
			entry_count_q <= cfg_data;
		end
	end

	always_comb begin
		if (entry_count_q == '0) begin
			cnt = CW'(1);
		end else if (32'(entry_count_q) > TABLE_DEPTH) begin
			cnt = CW'(TABLE_DEPTH);
		end else begin
			cnt = CW'(entry_count_q);
		end
	end

	cti_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.entry_index (entry_index),
		.month       (month),
		.day         (day),
		.time_hhmm   (time_hhmm),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	cti_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	cti_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.count       (cnt),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_hhmm (result_hhmm),
		.bad_date    (bad_date),
		.stat        (stat)
	);

`ifndef SYNTHESIS
	// the divider only runs inside a query
	a_div_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_busy |-> stat.busy)
		else $error("divider running while back is idle");

	// a new result only comes out of a query in progress
	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(stat.busy))
		else $error("result without a query");

	// nothing is popped from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_ready && !pop_valid) |=> !stat.busy)
		else $error("back left idle without a queued command");
`endif

endmodule
